// ===== hdl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types, codes and helper functions for the playfair stream encryptor
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam logic [2:0] OP_CLEAR_KEY = 3'd0;
	localparam logic [2:0] OP_KEY_BYTE  = 3'd1;
	localparam logic [2:0] OP_KEY_DONE  = 3'd2;
	localparam logic [2:0] OP_TEXT_BYTE = 3'd3;
	localparam logic [2:0] OP_END_TEXT  = 3'd4;

	localparam logic [4:0] LETTER_I   = 5'd8;
	localparam logic [4:0] LETTER_J   = 5'd9;
	localparam logic [4:0] LETTER_X   = 5'd23;
	localparam logic [4:0] LETTER_Z   = 5'd25;
	localparam logic [4:0] GRID_CELLS = 5'd25;
	localparam logic [2:0] GRID_SIDE  = 3'd5;
	localparam logic [6:0] ASCII_A    = 7'd65;

	localparam logic [25:0] USED_RESET = 26'd1 << LETTER_J;

	typedef struct packed {
		logic capture;
		logic clear_key;
		logic place_key;
		logic walk_start;
		logic walk_step;
		logic hold;
		logic pair_load;
		logic pair_pad;
		logic keep_held;
		logic pos_rd_a;
		logic pos_rd_b;
		logic calc;
		logic grid_rd_a;
		logic grid_rd_b;
		logic load_first;
		logic load_second;
	} cmd_t;

	typedef struct packed {
		logic key_ready;
		logic let_ok;
		logic held_valid;
		logic held_eq;
		logic walk_last;
		logic out_free;
	} status_t;

	// {is_letter, index} with j folded into i
	function automatic logic [5:0] letter_of(input logic [7:0] b);
		logic [4:0] idx;
		logic       ok;
		idx = 5'd0;
		ok  = 1'b0;
		if (b >= 8'd65 && b <= 8'd90) begin
			idx = 5'(b - 8'd65);
			ok  = 1'b1;
		end else if (b >= 8'd97 && b <= 8'd122) begin
			idx = 5'(b - 8'd97);
			ok  = 1'b1;
		end
		if (idx == LETTER_J) begin
			idx = LETTER_I;
		end
		return {ok, idx};
	endfunction

	// {row, col} of a grid cell
	function automatic logic [5:0] row_col(input logic [4:0] p);
		logic [2:0] row;
		logic [4:0] base;
		if (p >= 5'd20) begin
			row = 3'd4;
		end else if (p >= 5'd15) begin
			row = 3'd3;
		end else if (p >= 5'd10) begin
			row = 3'd2;
		end else if (p >= 5'd5) begin
			row = 3'd1;
		end else begin
			row = 3'd0;
		end
		base = 5'({row, 2'b00}) + 5'(row);
		return {row, 3'(p - base)};
	endfunction

	function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
		return 5'({row, 2'b00}) + 5'(row) + 5'(col);
	endfunction

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == GRID_SIDE - 3'd1) ? 3'd0 : v + 3'd1;
	endfunction

endpackage

// ===== hdl/pfe_ram.sv =====
// ----------------------------------------------------------------------------
// pfe_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/pfe_datapath.sv =====
// ----------------------------------------------------------------------------
// pfe_datapath
// key state, grid and position memories, pair arithmetic and output word
// ----------------------------------------------------------------------------
module pfe_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  pfe_pkg::cmd_t  cmd,
	output pfe_pkg::status_t sts,
	input  logic [7:0]     char_byte,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [6:0]     cipher_letter,
	output logic           last_of_pair
);

	logic [4:0]  let_q;
	logic        let_ok_q;
	logic [25:0] used_q;
	logic [4:0]  fill_q;
	logic        key_ready_q;
	logic [4:0]  held_letter_q;
	logic        held_valid_q;
	logic [4:0]  walk_q;
	logic [4:0]  a_q;
	logic [4:0]  b_q;
	logic [2:0]  r1_q;
	logic [2:0]  c1_q;
	logic [4:0]  o1_q;
	logic [4:0]  o2_q;
	logic        out_valid_q;
	logic [6:0]  cipher_q;
	logic        last_q;

	logic [5:0]  in_let;
	logic [4:0]  place_idx;
	logic [25:0] place_mask;
	logic        place_en;
	logic [4:0]  pos_rdata;
	logic [4:0]  grid_rdata;
	logic [5:0]  rc1;
	logic [5:0]  rc2;
	logic [2:0]  r2;
	logic [2:0]  c2;
	logic        out_free;

	assign in_let     = pfe_pkg::letter_of(char_byte);
	assign place_idx  = cmd.walk_step ? walk_q : let_q;
	assign place_mask = 26'd1 << place_idx;
	assign place_en   = (cmd.place_key || cmd.walk_step) && ((used_q & place_mask) == 26'd0)
		&& (fill_q < pfe_pkg::GRID_CELLS);
	assign rc1        = pfe_pkg::row_col(pos_rdata);
	assign rc2        = pfe_pkg::row_col(pos_rdata);
	assign r2         = rc2[5:3];
	assign c2         = rc2[2:0];
	assign out_free   = !out_valid_q || out_ready;

	pfe_ram #(.WIDTH(5), .DEPTH(26)) u_pos_ram (
		.clk   (clk),
		.we    (place_en),
		.waddr (place_idx),
		.wdata (fill_q),
		.re    (cmd.pos_rd_a || cmd.pos_rd_b),
		.raddr (cmd.pos_rd_b ? b_q : a_q),
		.rdata (pos_rdata)
	);

	pfe_ram #(.WIDTH(5), .DEPTH(25)) u_grid_ram (
		.clk   (clk),
		.we    (place_en),
		.waddr (fill_q),
		.wdata (place_idx),
		.re    (cmd.grid_rd_a || cmd.grid_rd_b),
		.raddr (cmd.grid_rd_b ? o2_q : o1_q),
		.rdata (grid_rdata)
	);

	// key and pairing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= pfe_pkg::USED_RESET;
			fill_q        <= 5'd0;
			key_ready_q   <= 1'b0;
			held_letter_q <= 5'd0;
			held_valid_q  <= 1'b0;
			walk_q        <= 5'd0;
		end else begin
			if (cmd.clear_key) begin
				used_q       <= pfe_pkg::USED_RESET;
				fill_q       <= 5'd0;
				key_ready_q  <= 1'b0;
				held_valid_q <= 1'b0;
			end
			if (place_en) begin
				used_q <= used_q | place_mask;
				fill_q <= fill_q + 5'd1;
			end
			if (cmd.walk_start) begin
				walk_q <= 5'd0;
			end
			if (cmd.walk_step) begin
				walk_q <= walk_q + 5'd1;
				if (walk_q == pfe_pkg::LETTER_Z) begin
					key_ready_q  <= 1'b1;
					held_valid_q <= 1'b0;
				end
			end
			if (cmd.hold) begin
				held_letter_q <= let_q;
				held_valid_q  <= 1'b1;
			end
			if (cmd.pair_load) begin
				if (cmd.keep_held) begin
					held_letter_q <= let_q;
				end else begin
					held_valid_q <= 1'b0;
				end
			end
		end
	end

	// captured letter and pair working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			let_q    <= in_let[4:0];
			let_ok_q <= in_let[5];
		end
		if (cmd.pair_load) begin
			a_q <= held_letter_q;
			b_q <= cmd.pair_pad ? pfe_pkg::LETTER_X : let_q;
		end
		if (cmd.pos_rd_b) begin
			r1_q <= rc1[5:3];
			c1_q <= rc1[2:0];
		end
		if (cmd.calc) begin
			if (r1_q == r2) begin
				o1_q <= pfe_pkg::cell_of(r1_q, pfe_pkg::wrap_inc(c1_q));
				o2_q <= pfe_pkg::cell_of(r2, pfe_pkg::wrap_inc(c2));
			end else if (c1_q == c2) begin
				o1_q <= pfe_pkg::cell_of(pfe_pkg::wrap_inc(r1_q), c1_q);
				o2_q <= pfe_pkg::cell_of(pfe_pkg::wrap_inc(r2), c2);
			end else begin
				o1_q <= pfe_pkg::cell_of(r1_q, c2);
				o2_q <= pfe_pkg::cell_of(r2, c1_q);
			end
		end
		if (cmd.load_first || cmd.load_second) begin
			cipher_q <= pfe_pkg::ASCII_A + {2'b00, grid_rdata};
			last_q   <= cmd.load_second;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_first || cmd.load_second) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.key_ready  = key_ready_q;
	assign sts.let_ok     = let_ok_q;
	assign sts.held_valid = held_valid_q;
	assign sts.held_eq    = (held_letter_q == let_q);
	assign sts.walk_last  = (walk_q == pfe_pkg::LETTER_Z);
	assign sts.out_free   = out_free;

	assign out_valid     = out_valid_q;
	assign cipher_letter = cipher_q;
	assign last_of_pair  = last_q;

endmodule

// ===== hdl/pfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfe_ctrl
// controller state machine sequencing decode, key walk and pair encryption
// ----------------------------------------------------------------------------
module pfe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       opcode,
	input  pfe_pkg::status_t sts,
	output pfe_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECODE = 4'd1;
	localparam logic [3:0] ST_WALK   = 4'd2;
	localparam logic [3:0] ST_POS_A  = 4'd3;
	localparam logic [3:0] ST_POS_B  = 4'd4;
	localparam logic [3:0] ST_CALC   = 4'd5;
	localparam logic [3:0] ST_GRID_A = 4'd6;
	localparam logic [3:0] ST_WAIT1  = 4'd7;
	localparam logic [3:0] ST_WAIT2  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [2:0] op_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (op_q)
					pfe_pkg::OP_CLEAR_KEY: begin
						cmd.clear_key = 1'b1;
					end
					pfe_pkg::OP_KEY_BYTE: begin
						cmd.place_key = !sts.key_ready && sts.let_ok;
					end
					pfe_pkg::OP_KEY_DONE: begin
						if (!sts.key_ready) begin
							cmd.walk_start = 1'b1;
							state_d        = ST_WALK;
						end
					end
					pfe_pkg::OP_TEXT_BYTE: begin
						if (sts.key_ready && sts.let_ok) begin
							if (!sts.held_valid) begin
								cmd.hold = 1'b1;
							end else begin
								cmd.pair_load = 1'b1;
								cmd.pair_pad  = sts.held_eq;
								cmd.keep_held = sts.held_eq;
								state_d       = ST_POS_A;
							end
						end
					end
					pfe_pkg::OP_END_TEXT: begin
						if (sts.key_ready && sts.held_valid) begin
							cmd.pair_load = 1'b1;
							cmd.pair_pad  = 1'b1;
							state_d       = ST_POS_A;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_POS_A: begin
				cmd.pos_rd_a = 1'b1;
				state_d      = ST_POS_B;
			end
			ST_POS_B: begin
				cmd.pos_rd_b = 1'b1;
				state_d      = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_GRID_A;
			end
			ST_GRID_A: begin
				cmd.grid_rd_a = 1'b1;
				state_d       = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (sts.out_free) begin
					cmd.load_first = 1'b1;
					cmd.grid_rd_b  = 1'b1;
					state_d        = ST_WAIT2;
				end
			end
			ST_WAIT2: begin
				if (sts.out_free) begin
					cmd.load_second = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= pfe_pkg::OP_CLEAR_KEY;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				op_q <= opcode;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ===== hdl/playfair_stream_encrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_stream_encrypt
// 5x5 playfair encryptor fed by opcoded byte words, controller plus datapath
// a word is captured in idle, then decoded; key done adds a walk over the letters a to z
// text pair: pos_a, pos_b, calc, grid_a, then wait1 and wait2 load the two letters
// a pair-completing word holds the input until both letters load, longer on a busy output
// the next word is taken while the last letter of a pair still waits at the output
// reset: arst_n clears control state; grid memories hold stale data until a key is loaded
// ----------------------------------------------------------------------------
module playfair_stream_encrypt (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] opcode,
	input  logic [7:0] char_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] cipher_letter,
	output logic       last_of_pair
);

	pfe_pkg::cmd_t    cmd;
	pfe_pkg::status_t sts;

	pfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.char_byte     (char_byte),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.cipher_letter (cipher_letter),
		.last_of_pair  (last_of_pair)
	);

endmodule

// ===== hdl/pfe_checker.sv =====
// ----------------------------------------------------------------------------
// pfe_checker
// port-level checks on the playfair stream encryptor, bound to the top level
// ----------------------------------------------------------------------------
module pfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] cipher_letter,
	input logic       last_of_pair
);

	// stalled output word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_letter) && $stable(last_of_pair))
	else $error("output word changed while stalled");

	// ciphertext is always an upper-case letter
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cipher_letter >= 7'd65 && cipher_letter <= 7'd90)
	else $error("cipher letter out of range");

	// no new word can appear the cycle after an input word is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
	else $error("output appeared too early");

	// second letter of a pair is pending while the first waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_pair |-> !in_ready)
	else $error("input taken in the middle of a pair");

endmodule

bind playfair_stream_encrypt pfe_checker u_pfe_checker (.*);

// ===== tb/sv/playfair_stream_encrypt_test.sv =====
// ----------------------------------------------------------------------------
// playfair_stream_encrypt_test
// Self-checking testbench for the playfair stream encryptor. It loads keys and
// text, predicts each cipher letter from its own grid model, and checks every
// output word in order. It covers directed key and text rules, random sessions
// under three idle mixes, and a long output hold-off that stalls the input.
// ----------------------------------------------------------------------------
module playfair_stream_encrypt_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_OFF    = 300;
	localparam int PHASE_WORDS = 170;

	typedef struct packed {
		logic [6:0] letter;
		logic       last;
	} cipher_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] opcode;
	logic [7:0] char_byte;
	logic       out_valid;
	logic       out_ready;
	logic [6:0] cipher_letter;
	logic       last_of_pair;

	// grid model
	logic [4:0]  key_grid [25];
	logic [4:0]  key_pos  [26];
	logic [25:0] placed;
	int          filled;
	bit          armed;
	logic [4:0]  held;
	bit          holding;

	cipher_word_t pending_letters[$];

	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	int err_count;
	int words_sent;
	int words_acting;
	int letters_checked;
	int cycle_count;

	playfair_stream_encrypt uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.char_byte    (char_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cipher_letter(cipher_letter),
		.last_of_pair (last_of_pair)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#(CLK_PERIOD / 2) clk = ~clk;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("error at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// letter index 0..25 with j folded into i, -1 for anything else
	function automatic int fold_letter(input logic [7:0] b);
		int idx;
		if (b >= "A" && b <= "Z") begin
			idx = int'(b) - 65;
		end else if (b >= "a" && b <= "z") begin
			idx = int'(b) - 97;
		end else begin
			return -1;
		end
		if (idx == int'(pfe_pkg::LETTER_J)) begin
			idx = int'(pfe_pkg::LETTER_I);
		end
		return idx;
	endfunction

	task automatic add_to_grid(input logic [4:0] idx);
		if (filled < 25 && !placed[idx]) begin
			key_grid[filled] = idx;
			key_pos[idx]     = 5'(filled);
			placed[idx]      = 1'b1;
			filled++;
		end
	endtask

	task automatic push_pair(input logic [4:0] a, input logic [4:0] b);
		int p1, p2, r1, c1, r2, c2, o1, o2;
		p1 = int'(key_pos[a]);
		p2 = int'(key_pos[b]);
		r1 = p1 / 5;
		c1 = p1 % 5;
		r2 = p2 / 5;
		c2 = p2 % 5;
		if (r1 == r2) begin
			o1 = r1 * 5 + (c1 + 1) % 5;
			o2 = r2 * 5 + (c2 + 1) % 5;
		end else if (c1 == c2) begin
			o1 = ((r1 + 1) % 5) * 5 + c1;
			o2 = ((r2 + 1) % 5) * 5 + c2;
		end else begin
			o1 = r1 * 5 + c2;
			o2 = r2 * 5 + c1;
		end
		pending_letters.push_back('{letter: pfe_pkg::ASCII_A + 7'(key_grid[o1]), last: 1'b0});
		pending_letters.push_back('{letter: pfe_pkg::ASCII_A + 7'(key_grid[o2]), last: 1'b1});
	endtask

	task automatic predict_word(input logic [2:0] op, input logic [7:0] b, output bit acted);
		int l;
		int i;
		acted = 1'b0;
		l = fold_letter(b);
		case (op)
			pfe_pkg::OP_CLEAR_KEY: begin
				placed  = pfe_pkg::USED_RESET;
				filled  = 0;
				armed   = 1'b0;
				holding = 1'b0;
				acted   = 1'b1;
			end
			pfe_pkg::OP_KEY_BYTE: begin
				if (!armed && l >= 0) begin
					add_to_grid(5'(l));
					acted = 1'b1;
				end
			end
			pfe_pkg::OP_KEY_DONE: begin
				if (!armed) begin
					for (i = 0; i < 26; i++) begin
						add_to_grid(5'(i));
					end
					armed   = 1'b1;
					holding = 1'b0;
					acted   = 1'b1;
				end
			end
			pfe_pkg::OP_TEXT_BYTE: begin
				if (armed && l >= 0) begin
					acted = 1'b1;
					if (!holding) begin
						held    = 5'(l);
						holding = 1'b1;
					end else if (held == 5'(l)) begin
						push_pair(held, pfe_pkg::LETTER_X);
					end else begin
						holding = 1'b0;
						push_pair(held, 5'(l));
					end
				end
			end
			pfe_pkg::OP_END_TEXT: begin
				if (armed && holding) begin
					holding = 1'b0;
					push_pair(held, pfe_pkg::LETTER_X);
					acted = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_word(input logic [2:0] op, input logic [7:0] b);
		bit acted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		char_byte <= b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_word(op, b, acted);
		words_sent++;
		if (acted) begin
			words_acting++;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_letters.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [7:0] letter_byte(input int idx);
		return ($urandom_range(1) ? 8'd97 : 8'd65) + 8'(idx);
	endfunction

	// receiver: random stalls plus a counted hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// output checker
	initial begin
		cipher_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_letters.size() == 0) begin
					report_error($sformatf("unexpected letter %0d", cipher_letter));
				end else begin
					want = pending_letters.pop_front();
					letters_checked++;
					if (cipher_letter !== want.letter) begin
						report_error($sformatf("cipher_letter got %0d expected %0d",
							cipher_letter, want.letter));
					end
					if (last_of_pair !== want.last) begin
						report_error($sformatf("last_of_pair got %0d expected %0d",
							last_of_pair, want.last));
					end
				end
			end
		end
	end

	task automatic test_key_loading();
		send_word(pfe_pkg::OP_TEXT_BYTE, "A");
		send_word(pfe_pkg::OP_END_TEXT, 8'h00);
		send_word(pfe_pkg::OP_CLEAR_KEY, 8'hFF);
		send_word(pfe_pkg::OP_KEY_BYTE, "p");
		send_word(pfe_pkg::OP_KEY_BYTE, "L");
		send_word(pfe_pkg::OP_KEY_BYTE, 8'h00);
		send_word(pfe_pkg::OP_KEY_BYTE, "a");
		send_word(pfe_pkg::OP_KEY_BYTE, "y");
		send_word(pfe_pkg::OP_KEY_BYTE, 8'h40);
		send_word(pfe_pkg::OP_KEY_BYTE, 8'h5B);
		send_word(pfe_pkg::OP_KEY_BYTE, 8'h60);
		send_word(pfe_pkg::OP_KEY_BYTE, 8'h7B);
		send_word(pfe_pkg::OP_KEY_BYTE, 8'h80);
		send_word(pfe_pkg::OP_KEY_BYTE, 8'hFF);
		send_word(pfe_pkg::OP_KEY_BYTE, "F");
		send_word(pfe_pkg::OP_KEY_BYTE, "i");
		send_word(pfe_pkg::OP_KEY_BYTE, "J");
		send_word(pfe_pkg::OP_KEY_BYTE, "r");
		send_word(pfe_pkg::OP_KEY_BYTE, "E");
		send_word(pfe_pkg::OP_KEY_BYTE, "x");
		send_word(pfe_pkg::OP_KEY_BYTE, "Z");
		send_word(pfe_pkg::OP_KEY_DONE, 8'h55);
		send_word(pfe_pkg::OP_KEY_DONE, 8'hAA);
		send_word(pfe_pkg::OP_KEY_BYTE, "q");
		drain();
	endtask

	task automatic test_text_rules();
		send_word(pfe_pkg::OP_TEXT_BYTE, "h");
		send_word(pfe_pkg::OP_TEXT_BYTE, "C");
		send_word(pfe_pkg::OP_TEXT_BYTE, "P");
		send_word(pfe_pkg::OP_TEXT_BYTE, "a");
		send_word(pfe_pkg::OP_TEXT_BYTE, "A");
		send_word(pfe_pkg::OP_TEXT_BYTE, 8'h2E);
		send_word(pfe_pkg::OP_TEXT_BYTE, "e");
		send_word(pfe_pkg::OP_TEXT_BYTE, "L");
		send_word(pfe_pkg::OP_TEXT_BYTE, "l");
		send_word(pfe_pkg::OP_TEXT_BYTE, "x");
		send_word(pfe_pkg::OP_TEXT_BYTE, "X");
		send_word(pfe_pkg::OP_TEXT_BYTE, "x");
		send_word(pfe_pkg::OP_END_TEXT, 8'h00);
		send_word(pfe_pkg::OP_END_TEXT, 8'h00);
		send_word(pfe_pkg::OP_TEXT_BYTE, "j");
		send_word(pfe_pkg::OP_TEXT_BYTE, "i");
		send_word(pfe_pkg::OP_TEXT_BYTE, "z");
		send_word(3'd5, "B");
		send_word(3'd6, "C");
		send_word(3'd7, 8'hFF);
		send_word(pfe_pkg::OP_END_TEXT, 8'h00);
		drain();
	endtask

	task automatic run_session();
		int roll, key_len, text_len, last_idx, idx, pick, k;
		roll = $urandom_range(99);
		if (roll < 12) begin
			repeat ($urandom_range(1, 12)) begin
				send_word(3'($urandom_range(7)), 8'($urandom_range(255)));
			end
			return;
		end
		send_word(pfe_pkg::OP_CLEAR_KEY, 8'($urandom_range(255)));
		key_len = ($urandom_range(9) == 0) ? $urandom_range(26, 40) : $urandom_range(0, 12);
		repeat (key_len) begin
			if ($urandom_range(9) == 0) begin
				send_word(pfe_pkg::OP_KEY_BYTE, 8'($urandom_range(255)));
			end else begin
				send_word(pfe_pkg::OP_KEY_BYTE, letter_byte($urandom_range(25)));
			end
		end
		// a few sessions skip key done here; their text is dropped unless the extra key done arms them
		if (roll >= 18) begin
			send_word(pfe_pkg::OP_KEY_DONE, 8'($urandom_range(255)));
		end
		if ($urandom_range(9) == 0) begin
			send_word(pfe_pkg::OP_KEY_DONE, 8'($urandom_range(255)));
			send_word(pfe_pkg::OP_KEY_BYTE, letter_byte($urandom_range(25)));
		end
		text_len = ($urandom_range(7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
		last_idx = int'(pfe_pkg::LETTER_X);
		for (k = 0; k < text_len; k++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_word(pfe_pkg::OP_TEXT_BYTE, 8'($urandom_range(255)));
			end else begin
				if (pick < 28) begin
					idx = last_idx;
				end else if (pick < 36) begin
					idx = int'(pfe_pkg::LETTER_X);
				end else begin
					idx = $urandom_range(25);
				end
				send_word(pfe_pkg::OP_TEXT_BYTE, letter_byte(idx));
				last_idx = idx;
			end
		end
		if ($urandom_range(3) != 0) begin
			send_word(pfe_pkg::OP_END_TEXT, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int goal;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		goal = words_sent + PHASE_WORDS;
		while (words_sent < goal) begin
			run_session();
		end
		drain();
	endtask

	task automatic test_output_hold_off();
		int k;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_word(pfe_pkg::OP_CLEAR_KEY, 8'h00);
		send_word(pfe_pkg::OP_KEY_BYTE, letter_byte($urandom_range(25)));
		send_word(pfe_pkg::OP_KEY_DONE, 8'h00);
		stall_left = HOLD_OFF;
		for (k = 0; k < 40; k++) begin
			send_word(pfe_pkg::OP_TEXT_BYTE, letter_byte($urandom_range(25)));
		end
		send_word(pfe_pkg::OP_END_TEXT, 8'h00);
		drain();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		opcode          = pfe_pkg::OP_CLEAR_KEY;
		char_byte       = 8'h00;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		stall_left      = 0;
		err_count       = 0;
		words_sent      = 0;
		words_acting    = 0;
		letters_checked = 0;
		placed          = pfe_pkg::USED_RESET;
		filled          = 0;
		armed           = 1'b0;
		held            = 5'd0;
		holding         = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_key_loading();
		test_text_rules();
		test_random_traffic(26, 64);
		test_random_traffic(64, 26);
		test_random_traffic(0, 0);
		test_output_hold_off();

		if (pending_letters.size() != 0) begin
			report_error($sformatf("%0d letters never arrived", pending_letters.size()));
		end
		$display("run: %0d words sent, %0d changed state, %0d cipher letters checked",
			words_sent, words_acting, letters_checked);
		$display("run: key and text rules, three stall mixes, %0d-cycle output hold-off",
			HOLD_OFF);
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
